// ===== rtl/core/u8cw_pkg.sv =====
`default_nettype none

package u8cw_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned COL_W    = 12;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned CELL_W   = 3;
  localparam int unsigned MAX_COLUMN_DEF = 4095;
  localparam int unsigned COL_FIELD_MAX  = (1 << COL_W) - 1;

  typedef struct packed {
    logic              vld;
    logic              tab;
    logic [CNT_W-1:0]  len;
    logic              seq_ok;
    logic [CP_W-1:0]   cp;
    logic [BYTE_W-1:0] lead;
    logic [COL_W-1:0]  col;
  } dec_t;

  typedef struct packed {
    logic              vld;
    logic [CNT_W-1:0]  used;
    logic [CP_W-1:0]   cp;
    logic [CELL_W-1:0] cells;
    logic              ok;
    logic [COL_W-1:0]  col;
  } cls_t;

endpackage

`default_nettype wire

// ===== rtl/core/u8cw_decode.sv =====
`default_nettype none

module u8cw_decode (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [u8cw_pkg::BYTE_W-1:0]   byte_first,
  input  wire logic [u8cw_pkg::BYTE_W-1:0]   byte_second,
  input  wire logic [u8cw_pkg::BYTE_W-1:0]   byte_third,
  input  wire logic [u8cw_pkg::BYTE_W-1:0]   byte_fourth,
  input  wire logic [u8cw_pkg::CNT_W-1:0]    bytes_present,
  input  wire logic [u8cw_pkg::COL_W-1:0]    column_now,
  output u8cw_pkg::dec_t                     dec_o
);

  logic                         vld_r;
  u8cw_pkg::dec_t               pay_r;
  u8cw_pkg::dec_t               pay_nxt;
  logic [u8cw_pkg::CNT_W-1:0]   avail;
  logic                         c1;
  logic                         c2;
  logic                         c3;

  always_comb begin
    if (bytes_present == 3'd0) begin
      avail = 3'd1;
    end else if (bytes_present > 3'd4) begin
      avail = 3'd4;
    end else begin
      avail = bytes_present;
    end
  end

  assign c1 = (byte_second[7:6] == 2'b10);
  assign c2 = (byte_third[7:6]  == 2'b10);
  assign c3 = (byte_fourth[7:6] == 2'b10);

  always_comb begin
    pay_nxt      = '0;
    pay_nxt.vld  = 1'b1;
    pay_nxt.tab  = (byte_first == 8'h09);
    pay_nxt.lead = byte_first;
    pay_nxt.col  = column_now;
    if (byte_first[7] == 1'b0) begin
      pay_nxt.len    = 3'd1;
      pay_nxt.seq_ok = 1'b1;
      pay_nxt.cp     = {13'd0, byte_first};
    end else if (byte_first[7:5] == 3'b110) begin
      pay_nxt.len    = 3'd2;
      pay_nxt.seq_ok = (avail >= 3'd2) && c1;
      pay_nxt.cp     = {10'd0, byte_first[4:0], byte_second[5:0]};
    end else if (byte_first[7:4] == 4'b1110) begin
      pay_nxt.len    = 3'd3;
      pay_nxt.seq_ok = (avail >= 3'd3) && c1 && c2;
      pay_nxt.cp     = {5'd0, byte_first[3:0], byte_second[5:0], byte_third[5:0]};
    end else if (byte_first[7:3] == 5'b11110) begin
      pay_nxt.len    = 3'd4;
      pay_nxt.seq_ok = (avail == 3'd4) && c1 && c2 && c3;
      pay_nxt.cp     = {byte_first[2:0], byte_second[5:0], byte_third[5:0],
                        byte_fourth[5:0]};
    end else begin
      pay_nxt.len    = 3'd1;
      pay_nxt.seq_ok = 1'b0;
      pay_nxt.cp     = {13'd0, byte_first};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pay_r <= pay_nxt;
    end
  end

  always_comb begin
    dec_o     = pay_r;
    dec_o.vld = vld_r;
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8cw_classify.sv =====
`default_nettype none

module u8cw_classify (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire u8cw_pkg::dec_t dec_i,
  output u8cw_pkg::cls_t cls_o
);

  logic                  vld_r;
  u8cw_pkg::cls_t        pay_r;
  u8cw_pkg::cls_t        pay_nxt;
  logic                  bad_val;
  logic                  ok;
  logic [u8cw_pkg::CP_W-1:0] cp_fin;

  function automatic logic [1:0] width_of(input logic [u8cw_pkg::CP_W-1:0] cp);
    logic [1:0] w;
    w = 2'd1;
    if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) begin
      w = 2'd0;
    end else if ((cp >= 21'h300 && cp <= 21'h36F) ||
                 (cp >= 21'h200B && cp <= 21'h200F) || cp == 21'hFEFF) begin
      w = 2'd0;
    end else if ((cp >= 21'h1100 && cp <= 21'h115F) ||
                 (cp >= 21'h2E80 && cp <= 21'h303E) ||
                 (cp >= 21'h3041 && cp <= 21'h33FF) ||
                 (cp >= 21'h3400 && cp <= 21'h4DBF) ||
                 (cp >= 21'h4E00 && cp <= 21'h9FFF) ||
                 (cp >= 21'hA000 && cp <= 21'hA4CF) ||
                 (cp >= 21'hAC00 && cp <= 21'hD7AF) ||
                 (cp >= 21'hF900 && cp <= 21'hFAFF) ||
                 (cp >= 21'hFE30 && cp <= 21'hFE4F) ||
                 (cp >= 21'hFF00 && cp <= 21'hFF60) ||
                 (cp >= 21'h20000 && cp <= 21'h3FFFD)) begin
      w = 2'd2;
    end
    return w;
  endfunction

  always_comb begin
    bad_val = ((dec_i.len == 3'd2) && (dec_i.cp < 21'h80))    ||
              ((dec_i.len == 3'd3) && (dec_i.cp < 21'h800))   ||
              ((dec_i.len == 3'd4) && (dec_i.cp < 21'h10000)) ||
              (dec_i.cp > 21'h10FFFF) ||
              ((dec_i.cp >= 21'hD800) && (dec_i.cp <= 21'hDFFF));
    ok      = dec_i.seq_ok && !bad_val;
    cp_fin  = ok ? dec_i.cp : {13'd0, dec_i.lead};
  end

  always_comb begin
    pay_nxt      = '0;
    pay_nxt.vld  = 1'b1;
    pay_nxt.col  = dec_i.col;
    pay_nxt.cp   = cp_fin;
    pay_nxt.ok   = ok;
    pay_nxt.used = ok ? dec_i.len : 3'd1;
    if (dec_i.tab) begin
      pay_nxt.cells = 3'd4 - {1'b0, dec_i.col[1:0]};
    end else begin
      pay_nxt.cells = {1'b0, width_of(cp_fin)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= dec_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_i.vld) begin
      pay_r <= pay_nxt;
    end
  end

  always_comb begin
    cls_o     = pay_r;
    cls_o.vld = vld_r;
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8cw_column.sv =====
`default_nettype none

module u8cw_column #(
  parameter int unsigned MAX_COLUMN = u8cw_pkg::MAX_COLUMN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire u8cw_pkg::cls_t                cls_i,
  output logic                               out_valid,
  output logic [u8cw_pkg::CNT_W-1:0]         out_bytes_used,
  output logic [u8cw_pkg::CP_W-1:0]          out_code_point,
  output logic [u8cw_pkg::CELL_W-1:0]        out_cell_count,
  output logic                               out_well_formed,
  output logic [u8cw_pkg::COL_W-1:0]         out_column_next
);

  localparam int unsigned CAP = (MAX_COLUMN > u8cw_pkg::COL_FIELD_MAX) ?
                                u8cw_pkg::COL_FIELD_MAX : MAX_COLUMN;
  localparam logic [u8cw_pkg::COL_W:0] CAP_V = (u8cw_pkg::COL_W + 1)'(CAP);

  logic                          valid_r;
  logic [u8cw_pkg::CNT_W-1:0]    used_r;
  logic [u8cw_pkg::CP_W-1:0]     cp_r;
  logic [u8cw_pkg::CELL_W-1:0]   cells_r;
  logic                          ok_r;
  logic [u8cw_pkg::COL_W-1:0]    col_r;
  logic [u8cw_pkg::COL_W-1:0]    col_nxt;
  logic [u8cw_pkg::COL_W:0]      sum;

  always_comb begin
    sum = {1'b0, cls_i.col} + {{(u8cw_pkg::COL_W + 1 - u8cw_pkg::CELL_W){1'b0}}, cls_i.cells};
    if (sum > CAP_V) begin
      col_nxt = CAP_V[u8cw_pkg::COL_W-1:0];
    end else begin
      col_nxt = sum[u8cw_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cls_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (cls_i.vld) begin
      used_r  <= cls_i.used;
      cp_r    <= cls_i.cp;
      cells_r <= cls_i.cells;
      ok_r    <= cls_i.ok;
      col_r   <= col_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_bytes_used  = used_r;
  assign out_code_point  = cp_r;
  assign out_cell_count  = cells_r;
  assign out_well_formed = ok_r;
  assign out_column_next = col_r;

endmodule

`default_nettype wire

// ===== rtl/core/utf8_cell_width_step.sv =====
// Channel   Ports                                   Handshake
// request   start, busy, in_byte_*, in_bytes_       taken when start && !busy
//           present, in_column_now
// result    out_valid, out_bytes_used, out_code_    one-cycle strobe, no stall
//           point, out_cell_count, out_well_
//           formed, out_column_next
//
// One request per cycle; each request passes through the decode, classify and column registers
// in turn, and out_valid rises when its result leaves the column register.
// Stages: byte decode, range check and width lookup, column add and saturate.
// busy stays low: each stage advances every cycle, so nothing waits on a stall.
// rst_n is synchronous and clears the valid bits of all three stages.
`default_nettype none

module utf8_cell_width_step #(
  parameter int unsigned MAX_COLUMN = u8cw_pkg::MAX_COLUMN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [u8cw_pkg::BYTE_W-1:0]   in_byte_first,
  input  wire logic [u8cw_pkg::BYTE_W-1:0]   in_byte_second,
  input  wire logic [u8cw_pkg::BYTE_W-1:0]   in_byte_third,
  input  wire logic [u8cw_pkg::BYTE_W-1:0]   in_byte_fourth,
  input  wire logic [u8cw_pkg::CNT_W-1:0]    in_bytes_present,
  input  wire logic [u8cw_pkg::COL_W-1:0]    in_column_now,
  output logic                               out_valid,
  output logic [u8cw_pkg::CNT_W-1:0]         out_bytes_used,
  output logic [u8cw_pkg::CP_W-1:0]          out_code_point,
  output logic [u8cw_pkg::CELL_W-1:0]        out_cell_count,
  output logic                               out_well_formed,
  output logic [u8cw_pkg::COL_W-1:0]         out_column_next
);

  u8cw_pkg::dec_t dec;
  u8cw_pkg::cls_t cls;
  logic           accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  u8cw_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .byte_first    (in_byte_first),
    .byte_second   (in_byte_second),
    .byte_third    (in_byte_third),
    .byte_fourth   (in_byte_fourth),
    .bytes_present (in_bytes_present),
    .column_now    (in_column_now),
    .dec_o         (dec)
  );

  u8cw_classify u_classify (
    .clk   (clk),
    .rst_n (rst_n),
    .dec_i (dec),
    .cls_o (cls)
  );

  u8cw_column #(
    .MAX_COLUMN (MAX_COLUMN)
  ) u_column (
    .clk             (clk),
    .rst_n           (rst_n),
    .cls_i           (cls),
    .out_valid       (out_valid),
    .out_bytes_used  (out_bytes_used),
    .out_code_point  (out_code_point),
    .out_cell_count  (out_cell_count),
    .out_well_formed (out_well_formed),
    .out_column_next (out_column_next)
  );

endmodule

`default_nettype wire

// ===== rtl/core/u8cw_checker.sv =====
`default_nettype none

module u8cw_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic [u8cw_pkg::CNT_W-1:0]    out_bytes_used,
  input wire logic [u8cw_pkg::CP_W-1:0]     out_code_point,
  input wire logic [u8cw_pkg::CELL_W-1:0]   out_cell_count,
  input wire logic                          out_well_formed
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("request did not produce a result after three cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 3))
    else $error("result without a matching request");

  a_raw_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_well_formed) |-> (out_bytes_used == 3'd1))
    else $error("raw byte fallback consumed more than one byte");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bytes_used != 3'd0 && out_bytes_used <= 3'd4 &&
                   out_cell_count <= 3'd4 &&
                   (out_cell_count <= 3'd2 || out_code_point == 21'd9)))
    else $error("result field out of range");

endmodule

bind utf8_cell_width_step u8cw_checker u_u8cw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_bytes_used  (out_bytes_used),
  .out_code_point  (out_code_point),
  .out_cell_count  (out_cell_count),
  .out_well_formed (out_well_formed)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 257;
  localparam int unsigned COL_CAP =
    (u8cw_pkg::MAX_COLUMN_DEF < u8cw_pkg::COL_FIELD_MAX) ?
    u8cw_pkg::MAX_COLUMN_DEF : u8cw_pkg::COL_FIELD_MAX;
  localparam logic [7:0] TAB_BYTE = 8'h09;

  typedef struct packed {
    logic [u8cw_pkg::CNT_W-1:0]  bytes_used;
    logic [u8cw_pkg::CP_W-1:0]   code_point;
    logic [u8cw_pkg::CELL_W-1:0] cell_count;
    logic                        well_formed;
    logic [u8cw_pkg::COL_W-1:0]  column_next;
  } char_result_t;

  typedef enum int unsigned {
    SEQ_GOOD, SEQ_OVERLONG, SEQ_SURROGATE, SEQ_ABOVE_MAX, SEQ_SHORT, SEQ_BAD_TAIL, SEQ_NOISE
  } seq_kind_t;

  class char_scoreboard;
    char_result_t expected_q[$];
    int unsigned  mismatches;
    int unsigned  col_cap;

    function new(int unsigned cap);
      col_cap    = cap;
      mismatches = 0;
    endfunction

    static function int unsigned cells_for(int unsigned cp);
      if (cp < 'h20 || (cp >= 'h7F && cp < 'hA0)) return 0;
      if ((cp >= 'h300 && cp <= 'h36F) || (cp >= 'h200B && cp <= 'h200F) || cp == 'hFEFF)
        return 0;
      if ((cp >= 'h1100 && cp <= 'h115F) || (cp >= 'h2E80 && cp <= 'h303E) ||
          (cp >= 'h3041 && cp <= 'h33FF) || (cp >= 'h3400 && cp <= 'h4DBF) ||
          (cp >= 'h4E00 && cp <= 'h9FFF) || (cp >= 'hA000 && cp <= 'hA4CF) ||
          (cp >= 'hAC00 && cp <= 'hD7AF) || (cp >= 'hF900 && cp <= 'hFAFF) ||
          (cp >= 'hFE30 && cp <= 'hFE4F) || (cp >= 'hFF00 && cp <= 'hFF60) ||
          (cp >= 'h20000 && cp <= 'h3FFFD))
        return 2;
      return 1;
    endfunction

    function void note_request(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                               logic [7:0] b3, logic [2:0] present, logic [11:0] col);
      logic [7:0]   seq [4];
      int unsigned  avail, len, cp, cells, next;
      bit           ok;
      char_result_t r;
      seq   = '{b0, b1, b2, b3};
      avail = (present == 0) ? 1 : ((present > 4) ? 4 : present);
      if (b0 == TAB_BYTE) begin
        len   = 1;
        cp    = TAB_BYTE;
        ok    = 1'b1;
        cells = 4 - col[1:0];
      end else begin
        len = 0;
        cp  = b0;
        if (b0 < 8'h80) begin
          len = 1;
        end else if (b0[7:5] == 3'b110) begin
          len = 2;
          cp  = b0[4:0];
        end else if (b0[7:4] == 4'b1110) begin
          len = 3;
          cp  = b0[3:0];
        end else if (b0[7:3] == 5'b11110) begin
          len = 4;
          cp  = b0[2:0];
        end
        ok = (len != 0) && (len <= avail);
        for (int i = 1; i < 4; i++) begin
          if (ok && i < len) begin
            if (seq[i][7:6] != 2'b10) ok = 1'b0;
            cp = (cp << 6) | seq[i][5:0];
          end
        end
        if (ok && ((len == 2 && cp < 'h80) || (len == 3 && cp < 'h800) ||
                   (len == 4 && cp < 'h10000) || cp > 'h10FFFF ||
                   (cp >= 'hD800 && cp <= 'hDFFF)))
          ok = 1'b0;
        if (!ok) begin
          len = 1;
          cp  = b0;
        end
        cells = cells_for(cp);
      end
      next = col + cells;
      if (next > col_cap) next = col_cap;
      r.bytes_used  = len[2:0];
      r.code_point  = cp[20:0];
      r.cell_count  = cells[2:0];
      r.well_formed = ok;
      r.column_next = next[11:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(char_result_t got);
      char_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request waiting: used=%0d cp=%h cells=%0d",
                   $realtime, got.bytes_used, got.code_point, got.cell_count,
                   " ok=%0b col=%0d", got.well_formed, got.column_next);
        return;
      end
      want = expected_q.pop_front();
      if (got.bytes_used != want.bytes_used || got.code_point != want.code_point ||
          got.cell_count != want.cell_count || got.well_formed != want.well_formed ||
          got.column_next != want.column_next) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected used=%0d cp=%h cells=%0d ok=%0b col=%0d,",
                   $realtime, want.bytes_used, want.code_point, want.cell_count,
                   want.well_formed, want.column_next,
                   " got used=%0d cp=%h cells=%0d ok=%0b col=%0d",
                   got.bytes_used, got.code_point, got.cell_count, got.well_formed,
                   got.column_next);
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [u8cw_pkg::BYTE_W-1:0]       in_byte_first;
  logic [u8cw_pkg::BYTE_W-1:0]       in_byte_second;
  logic [u8cw_pkg::BYTE_W-1:0]       in_byte_third;
  logic [u8cw_pkg::BYTE_W-1:0]       in_byte_fourth;
  logic [u8cw_pkg::CNT_W-1:0]        in_bytes_present;
  logic [u8cw_pkg::COL_W-1:0]        in_column_now;
  logic                              out_valid;
  logic [u8cw_pkg::CNT_W-1:0]        out_bytes_used;
  logic [u8cw_pkg::CP_W-1:0]         out_code_point;
  logic [u8cw_pkg::CELL_W-1:0]       out_cell_count;
  logic                              out_well_formed;
  logic [u8cw_pkg::COL_W-1:0]        out_column_next;

  char_scoreboard sb = new(COL_CAP);

  int unsigned code_edges[$] = '{
    'h00, 'h1F, 'h20, 'h7E, 'h7F, 'h9F, 'hA0, 'h2FF, 'h300, 'h36F, 'h370, 'h7FF,
    'h800, 'h10FF, 'h1100, 'h115F, 'h1160, 'h200A, 'h200B, 'h200F, 'h2010,
    'h2E7F, 'h2E80, 'h303E, 'h303F, 'h3040, 'h3041, 'h33FF, 'h3400, 'h4DBF,
    'h4DC0, 'h4DFF, 'h4E00, 'h9FFF, 'hA000, 'hA4CF, 'hA4D0, 'hABFF, 'hAC00,
    'hD7AF, 'hD7B0, 'hD7FF, 'hE000, 'hF8FF, 'hF900, 'hFAFF, 'hFB00, 'hFE2F,
    'hFE30, 'hFE4F, 'hFE50, 'hFEFE, 'hFEFF, 'hFF00, 'hFF60, 'hFF61, 'hFFFF,
    'h10000, 'h1FFFF, 'h20000, 'h3FFFD, 'h3FFFE, 'h3FFFF, 'h10FFFF
  };

  utf8_cell_width_step i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_byte_first    (in_byte_first),
    .in_byte_second   (in_byte_second),
    .in_byte_third    (in_byte_third),
    .in_byte_fourth   (in_byte_fourth),
    .in_bytes_present (in_bytes_present),
    .in_column_now    (in_column_now),
    .out_valid        (out_valid),
    .out_bytes_used   (out_bytes_used),
    .out_code_point   (out_code_point),
    .out_cell_count   (out_cell_count),
    .out_well_formed  (out_well_formed),
    .out_column_next  (out_column_next)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_bytes_used, out_code_point, out_cell_count,
                        out_well_formed, out_column_next});
  end

  task automatic put_bytes(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                           input logic [7:0] b3, input logic [2:0] present,
                           input logic [11:0] col);
    in_byte_first    <= b0;
    in_byte_second   <= b1;
    in_byte_third    <= b2;
    in_byte_fourth   <= b3;
    in_bytes_present <= present;
    in_column_now    <= col;
    start            <= 1'b1;
    // hold the request until the block takes it
    do @(posedge clk); while (busy);
    sb.note_request(b0, b1, b2, b3, present, col);
  endtask

  task automatic hold_off(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [20:0] code_of_length(int unsigned len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range('h7F));
      2: cp = 21'($urandom_range('h7FF, 'h80));
      3: begin
        cp = 21'($urandom_range('hFFFF, 'h800));
        if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp - 21'h800;
      end
      default: cp = 21'($urandom_range('h10FFFF, 'h10000));
    endcase
    return cp;
  endfunction

  function automatic logic [20:0] pick_code();
    case ($urandom_range(4))
      0: return code_of_length($urandom_range(4, 1));
      1: return 21'(code_edges[$urandom_range(code_edges.size() - 1)]);
      2: return {13'd0, TAB_BYTE};
      3: return 21'($urandom_range('h3FFFF, 'h20000));
      default: return code_of_length($urandom_range(3, 2));
    endcase
  endfunction

  function automatic seq_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return SEQ_GOOD;
    if (r < 75) return SEQ_OVERLONG;
    if (r < 79) return SEQ_SURROGATE;
    if (r < 83) return SEQ_ABOVE_MAX;
    if (r < 88) return SEQ_SHORT;
    if (r < 93) return SEQ_BAD_TAIL;
    return SEQ_NOISE;
  endfunction

  task automatic put_random_char();
    logic [7:0]  b [4];
    logic [20:0] cp;
    logic [11:0] col;
    int unsigned len, avail, k;
    seq_kind_t   kind;
    for (int i = 0; i < 4; i++) b[i] = 8'($urandom);
    kind = pick_kind();
    cp   = pick_code();
    len  = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
    case (kind)
      SEQ_OVERLONG: begin
        len = $urandom_range(4, 2);
        cp  = 21'($urandom_range((len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
      end
      SEQ_SURROGATE: begin
        len = 3;
        cp  = 21'($urandom_range('hDFFF, 'hD800));
      end
      SEQ_ABOVE_MAX: begin
        len = 4;
        cp  = 21'($urandom_range('h1FFFFF, 'h110000));
      end
      SEQ_SHORT, SEQ_BAD_TAIL: begin
        len = $urandom_range(4, 2);
        cp  = code_of_length(len);
      end
      default: ;
    endcase
    avail = $urandom_range(4, len);
    if (avail == 4 && $urandom_range(7) == 0) avail = $urandom_range(7, 5);
    if (kind == SEQ_SHORT) avail = $urandom_range(len - 1, 0);
    if (kind == SEQ_NOISE) begin
      avail = $urandom_range(7);
    end else begin
      case (len)
        1: b[0] = cp[7:0];
        2: begin
          b[0] = {3'b110, cp[10:6]};
          b[1] = {2'b10, cp[5:0]};
        end
        3: begin
          b[0] = {4'b1110, cp[15:12]};
          b[1] = {2'b10, cp[11:6]};
          b[2] = {2'b10, cp[5:0]};
        end
        default: begin
          b[0] = {5'b11110, cp[20:18]};
          b[1] = {2'b10, cp[17:12]};
          b[2] = {2'b10, cp[11:6]};
          b[3] = {2'b10, cp[5:0]};
        end
      endcase
    end
    if (kind == SEQ_BAD_TAIL) begin
      k = $urandom_range(len - 1, 1);
      case ($urandom_range(2))
        0: b[k][7:6] = 2'b00;
        1: b[k][7:6] = 2'b01;
        default: b[k][7:6] = 2'b11;
      endcase
    end
    case ($urandom_range(3))
      0: col = 12'($urandom_range(4095, 4088));
      1: col = 12'($urandom_range(15));
      default: col = 12'($urandom);
    endcase
    put_bytes(b[0], b[1], b[2], b[3], 3'(avail), col);
  endtask

  initial begin
    int unsigned gap_pct [4];
    gap_pct = '{0, 81, 0, 9};
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_byte_first    <= '0;
    in_byte_second   <= '0;
    in_byte_third    <= '0;
    in_byte_fourth   <= '0;
    in_bytes_present <= 3'd1;
    in_column_now    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    put_bytes(8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0);
    put_bytes(TAB_BYTE, 8'h80, 8'h80, 8'h80, 3'd4, 12'd0);
    put_bytes(TAB_BYTE, 8'h00, 8'h00, 8'h00, 3'd1, 12'd5);
    put_bytes(TAB_BYTE, 8'h00, 8'h00, 8'h00, 3'd1, 12'd4094);
    put_bytes(TAB_BYTE, 8'h00, 8'h00, 8'h00, 3'd2, 12'd7);
    put_bytes(8'h7F, 8'h00, 8'h00, 8'h00, 3'd1, 12'd100);
    put_bytes(8'hFF, 8'hBF, 8'hBF, 8'hBF, 3'd4, 12'd10);
    put_bytes(8'h80, 8'h80, 8'h80, 8'h80, 3'd4, 12'd10);
    put_bytes(8'hC2, 8'h80, 8'h00, 8'h00, 3'd2, 12'd20);
    put_bytes(8'hC0, 8'h80, 8'h00, 8'h00, 3'd2, 12'd20);
    put_bytes(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3, 12'd30);
    put_bytes(8'hE0, 8'h80, 8'h80, 8'h00, 3'd3, 12'd30);
    put_bytes(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3, 12'd30);
    put_bytes(8'hEF, 8'hBB, 8'hBF, 8'h00, 3'd3, 12'd40);
    put_bytes(8'hF0, 8'h90, 8'h80, 8'h80, 3'd4, 12'd50);
    put_bytes(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4, 12'd50);
    put_bytes(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4, 12'd50);
    put_bytes(8'hE4, 8'hB8, 8'h80, 8'h00, 3'd2, 12'd60);
    put_bytes(8'hE4, 8'h38, 8'hAD, 8'h00, 3'd3, 12'd60);
    put_bytes(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd0, 12'd70);
    put_bytes(8'hF0, 8'hA0, 8'h80, 8'h80, 3'd7, 12'd80);
    put_bytes(8'h41, 8'h00, 8'h00, 8'h00, 3'd1, 12'd4095);
    put_bytes(8'hE4, 8'hB8, 8'h80, 8'h00, 3'd3, 12'd4094);
    put_bytes(8'hCC, 8'h80, 8'h00, 8'h00, 3'd5, 12'd90);

    foreach (gap_pct[p]) begin
      drain_results();
      repeat (PHASE_ITEMS) begin
        hold_off(gap_pct[p]);
        put_random_char();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== utf8_cell_width_step.f =====
rtl/core/u8cw_pkg.sv
rtl/core/u8cw_decode.sv
rtl/core/u8cw_classify.sv
rtl/core/u8cw_column.sv
rtl/core/utf8_cell_width_step.sv
rtl/core/u8cw_checker.sv
bench/testbench.sv
